>>> rtl/asad_pkg.sv
// Package for the step, shake and activity detector.
// Holds transaction types, register index codes, filter coefficients and
// the command type of the shared multiply-accumulate unit. No dependencies.
`default_nettype none

package asad_pkg;

   // Default fixed point fraction width
   localparam int FRAC_BITS_DEF = 16;

   // Fixed widths
   localparam int AXIS_W = 24;
   localparam int RAD_W  = 48;
   localparam int OPND_W = 25;
   localparam int ACC_W  = 51;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_RANGE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DEBOUNCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE_COOL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_HOLDOFF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_ENV_THR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_JERK_THR = 3'd5;

   // Unsigned Q16 filter coefficients
   localparam logic signed [OPND_W-1:0] C_098 = 25'sd64225;
   localparam logic signed [OPND_W-1:0] C_002 = 25'sd1311;
   localparam logic signed [OPND_W-1:0] C_065 = 25'sd42598;
   localparam logic signed [OPND_W-1:0] C_035 = 25'sd22938;
   localparam logic signed [OPND_W-1:0] C_030 = 25'sd19661;
   localparam logic signed [OPND_W-1:0] C_070 = 25'sd45875;
   localparam logic signed [OPND_W-1:0] C_060 = 25'sd39322;
   localparam logic signed [OPND_W-1:0] C_040 = 25'sd26214;
   localparam logic signed [OPND_W-1:0] C_160 = 25'sd104858;
   localparam logic signed [OPND_W-1:0] C_055 = 25'sd36045;

   typedef struct packed {
      logic signed [15:0] accel_x_raw;
      logic signed [15:0] accel_y_raw;
      logic signed [15:0] accel_z_raw;
      logic [31:0]        time_ms;
      logic               clear_shake;
   } req_type;

   typedef struct packed {
      logic step_pulse;
      logic shake_pending;
      logic activity_pulse;
   } rsp_type;

   typedef struct packed {
      logic                     en;
      logic                     clr;
      logic signed [OPND_W-1:0] a;
      logic signed [OPND_W-1:0] b;
   } mac_cmd_type;

endpackage

`default_nettype wire

>>> rtl/asad_mac.sv
// Shared multiply-accumulate unit with Q16 round-half-up and 24-bit saturation.
// Depends on asad_pkg.
`default_nettype none

module asad_mac (
   input  wire logic                           clock,
   input  wire asad_pkg::mac_cmd_type          cmd,
   output logic [asad_pkg::ACC_W-1:0]          acc,
   output logic [asad_pkg::AXIS_W-1:0]         rounded
);

   logic signed [asad_pkg::ACC_W-1:0] acc_ff;
   logic signed [asad_pkg::ACC_W-1:0] acc_in;
   logic signed [2*asad_pkg::OPND_W-1:0] prod;
   logic signed [asad_pkg::ACC_W-1:0] biased;
   logic [asad_pkg::ACC_W-17:0] shifted;

   // Multiply, then load or accumulate
   assign prod = cmd.a * cmd.b;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.en) begin
         if (cmd.clr) begin
            acc_in = asad_pkg::ACC_W'(prod);
         end else begin
            acc_in = acc_ff + asad_pkg::ACC_W'(prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round half up and saturate the non-negative sum
   assign biased  = acc_ff + asad_pkg::ACC_W'(32768);
   assign shifted = biased[asad_pkg::ACC_W-1:16];

   always_comb begin
      if (|shifted[asad_pkg::ACC_W-17:asad_pkg::AXIS_W]) begin
         rounded = {asad_pkg::AXIS_W{1'b1}};
      end else begin
         rounded = shifted[asad_pkg::AXIS_W-1:0];
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

>>> rtl/asad_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on asad_pkg.
`default_nettype none

module asad_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [asad_pkg::RAD_W-1:0]    radicand,
   output logic                               done,
   output logic [asad_pkg::AXIS_W-1:0]        root
);

   localparam int ITER = asad_pkg::RAD_W / 2;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [asad_pkg::RAD_W-1:0] n_ff, n_in;
   logic [asad_pkg::RAD_W-1:0] r_ff, r_in;
   logic [asad_pkg::RAD_W-1:0] bit_ff, bit_in;
   logic [asad_pkg::RAD_W-1:0] trial;

   assign trial = r_ff + bit_ff;

   // One root bit per iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = radicand;
         r_in    = '0;
         bit_in  = asad_pkg::RAD_W'(1) << (asad_pkg::RAD_W - 2);
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[asad_pkg::AXIS_W-1:0];

endmodule

`default_nettype wire

>>> rtl/accel_step_shake_activity_detect_unit.sv
// Step, shake and activity detector top level: sequencer and detector state.
// Depends on asad_pkg, asad_mac and asad_sqrt.
//
// Usage:
//  - Input channel req_valid/req_ready/req_data carries one accelerometer
//    sample transaction; result channel rsp_valid/rsp_ready/rsp_data returns
//    one result transaction per sample, in order.
//  - csr_we/csr_index/csr_wdata write the six configuration registers;
//    write only while no sample is in flight.
//  - A sample runs through the sequencer from acceptance to result; before the
//    first valid sample it goes straight to the result step. The 24-iteration
//    square root and the single shared multiply-accumulate unit set the time
//    in between. req_ready is high only while the sequencer waits for a
//    sample, so the next sample is accepted only once the current one is done.
//  - The result register decouples the sides: a new sample may be accepted
//    while the previous result is waiting; when the receiver stalls the
//    sequencer holds its final step until the result register frees up.
//  - Synchronous reset returns detector state and configuration registers to
//    defaults (not sample scratch or result data); no clearing pass is needed.
`default_nettype none

module accel_step_shake_activity_detect_unit #(
   parameter int FRAC_BITS = asad_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire asad_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output asad_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [asad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [asad_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   localparam int AW = asad_pkg::AXIS_W;

   // Fixed point constants
   localparam logic [AW-1:0] Q_ONE    = AW'(((64'd1 << FRAC_BITS) + 64'd0) / 64'd1);
   localparam logic [AW-1:0] Q_1_100  = AW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [AW-1:0] Q_1_20   = AW'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
   localparam logic [AW-1:0] Q_7_100  = AW'(((64'd7 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [AW-1:0] Q_13_20  = AW'(((64'd13 << FRAC_BITS) + 64'd10) / 64'd20);
   localparam logic [AW-1:0] Q_14_5   = AW'(((64'd14 << FRAC_BITS) + 64'd2) / 64'd5);
   localparam logic [AW-1:0] Q_2_25   = AW'(((64'd2 << FRAC_BITS) + 64'd12) / 64'd25);
   localparam logic [AW-1:0] Q_4_25   = AW'(((64'd4 << FRAC_BITS) + 64'd12) / 64'd25);

   // Sequencer codes
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CHECK = 5'd1;
   localparam logic [4:0] S_A1    = 5'd2;
   localparam logic [4:0] S_A2    = 5'd3;
   localparam logic [4:0] S_A3    = 5'd4;
   localparam logic [4:0] S_A4    = 5'd5;
   localparam logic [4:0] S_A5    = 5'd6;
   localparam logic [4:0] S_P1    = 5'd7;
   localparam logic [4:0] S_P2    = 5'd8;
   localparam logic [4:0] S_P3    = 5'd9;
   localparam logic [4:0] S_P4    = 5'd10;
   localparam logic [4:0] S_PW    = 5'd11;
   localparam logic [4:0] S_T1    = 5'd12;
   localparam logic [4:0] S_B2    = 5'd13;
   localparam logic [4:0] S_B3    = 5'd14;
   localparam logic [4:0] S_B4    = 5'd15;
   localparam logic [4:0] S_B5    = 5'd16;
   localparam logic [4:0] S_B6    = 5'd17;
   localparam logic [4:0] S_B7    = 5'd18;
   localparam logic [4:0] S_SH    = 5'd19;
   localparam logic [4:0] S_K2    = 5'd20;
   localparam logic [4:0] S_K3    = 5'd21;
   localparam logic [4:0] S_K4    = 5'd22;
   localparam logic [4:0] S_K5    = 5'd23;
   localparam logic [4:0] S_DONE  = 5'd24;

   // Scale a raw axis to Q format, truncating toward zero, then saturate
   function automatic logic signed [AW-1:0] scale_axis(input logic signed [15:0] raw,
                                                       input logic [5:0] sh);
      logic signed [47:0] wide;
      logic signed [47:0] q;
      logic signed [AW-1:0] res;
      wide = 48'(raw) <<< sh;
      if (wide < 0) begin
         wide = wide + 48'sd32767;
      end
      q = wide >>> 15;
      if (q > 48'sd8388607) begin
         res = 24'sh7FFFFF;
      end else if (q < -48'sd8388608) begin
         res = 24'sh800000;
      end else begin
         res = q[AW-1:0];
      end
      return res;
   endfunction

   function automatic logic [AW-1:0] abs_axis(input logic signed [AW-1:0] v);
      logic signed [AW:0] w;
      w = {v[AW-1], v};
      if (w < 0) begin
         w = -w;
      end
      return w[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] absdiff_s(input logic signed [AW-1:0] a,
                                               input logic signed [AW-1:0] b);
      logic signed [AW:0] d;
      logic [AW:0] m;
      d = {a[AW-1], a} - {b[AW-1], b};
      m = (d < 0) ? (AW+1)'(-d) : (AW+1)'(d);
      return m[AW] ? {AW{1'b1}} : m[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] absdiff_u(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic signed [asad_pkg::OPND_W-1:0] opnd(input logic [AW-1:0] v);
      return signed'({1'b0, v});
   endfunction

   // Configuration registers
   logic [1:0]  csr_range_ff;
   logic [15:0] csr_debounce_ff, csr_cooldown_ff, csr_holdoff_ff;
   logic [15:0] csr_env_thr_ff, csr_jerk_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_range_ff    <= 2'd0;
         csr_debounce_ff <= 16'd220;
         csr_cooldown_ff <= 16'd3000;
         csr_holdoff_ff  <= 16'd300;
         csr_env_thr_ff  <= 16'd2294;
         csr_jerk_thr_ff <= 16'd6554;
      end else if (csr_we) begin
         case (csr_index)
            asad_pkg::CSR_ACCEL_RANGE:   csr_range_ff    <= csr_wdata[1:0];
            asad_pkg::CSR_STEP_DEBOUNCE: csr_debounce_ff <= csr_wdata;
            asad_pkg::CSR_SHAKE_COOL:    csr_cooldown_ff <= csr_wdata;
            asad_pkg::CSR_ACT_HOLDOFF:   csr_holdoff_ff  <= csr_wdata;
            asad_pkg::CSR_STEP_ENV_THR:  csr_env_thr_ff  <= csr_wdata;
            asad_pkg::CSR_STEP_JERK_THR: csr_jerk_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Thresholds converted to Q format
   logic [35:0] env_thr_wide, jerk_thr_wide;
   logic [AW-1:0] env_thr_q, jerk_thr_q;
   assign env_thr_wide  = ({20'd0, csr_env_thr_ff} << FRAC_BITS) >> 16;
   assign jerk_thr_wide = ({20'd0, csr_jerk_thr_ff} << FRAC_BITS) >> 16;
   assign env_thr_q  = env_thr_wide[AW-1:0];
   assign jerk_thr_q = jerk_thr_wide[AW-1:0];

   // State
   logic [4:0] st_ff, st_in;
   logic valid_seen_ff, valid_seen_in;
   logic step_started_ff, step_started_in;
   logic above_ff, above_in;
   logic shake_started_ff, shake_started_in;
   logic shake_flag_ff, shake_flag_in;
   logic step_pulse_ff, step_pulse_in;
   logic act_pulse_ff, act_pulse_in;
   logic [AW-1:0] baseline_ff, baseline_in;
   logic [AW-1:0] step_env_ff, step_env_in;
   logic signed [AW-1:0] prior_ff [3];
   logic signed [AW-1:0] prior_in [3];
   logic signed [AW-1:0] ax_ff [3];
   logic signed [AW-1:0] ax_in [3];
   logic [31:0] now_ff, now_in;
   logic [31:0] last_step_ff, last_step_in;
   logic [31:0] last_shake_ff, last_shake_in;
   logic [31:0] last_act_ff, last_act_in;
   logic [AW-1:0] sh_mag_ff, sh_mag_in;
   logic [AW-1:0] sh_env_ff, sh_env_in;
   logic [AW-1:0] sh_jerk_ff, sh_jerk_in;
   logic [AW-1:0] shk_acc_env_ff, shk_acc_env_in;
   logic [AW-1:0] shk_jerk_env_ff, shk_jerk_env_in;
   logic [AW-1:0] act_env_ff, act_env_in;
   logic [AW-1:0] mag_ff, mag_in;
   logic [AW-1:0] jerk_ff, jerk_in;
   logic [AW-1:0] hp_ff, hp_in;
   logic [AW-1:0] sig_ff, sig_in;
   logic rsp_valid_ff, rsp_valid_in;
   asad_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Shared units
   asad_pkg::mac_cmd_type mac_cmd;
   logic [asad_pkg::ACC_W-1:0] mac_acc;
   logic [AW-1:0] mac_round;
   logic sq_start, sq_done;
   logic [AW-1:0] sq_root;

   asad_mac u_mac (
      .clock   (clock),
      .cmd     (mac_cmd),
      .acc     (mac_acc),
      .rounded (mac_round)
   );

   asad_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (mac_acc[asad_pkg::RAD_W-1:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   // Combinational helpers
   logic [5:0] scale_sh;
   logic [AW+1:0] abssum;
   logic [AW+1:0] jerk_sum;
   logic [AW-1:0] shake_hp;
   logic over, jerk_hit, moved, jerked, big_shake;

   assign scale_sh = 6'(FRAC_BITS + 1) + {4'd0, csr_range_ff};
   assign abssum = (AW+2)'(abs_axis(ax_ff[0])) + (AW+2)'(abs_axis(ax_ff[1]))
                 + (AW+2)'(abs_axis(ax_ff[2]));
   assign jerk_sum = (AW+2)'(absdiff_s(ax_ff[0], prior_ff[0]))
                   + (AW+2)'(absdiff_s(ax_ff[1], prior_ff[1]))
                   + (AW+2)'(absdiff_s(ax_ff[2], prior_ff[2]));
   assign shake_hp = absdiff_u(sh_mag_ff, Q_ONE);
   assign over     = step_env_ff > env_thr_q;
   assign jerk_hit = (jerk_ff > jerk_thr_q) && (step_env_ff > mac_round)
                   && (mag_ff > Q_13_20) && (mag_ff < Q_14_5);
   assign moved     = shk_acc_env_ff > Q_2_25;
   assign jerked    = mac_round > Q_4_25;
   assign big_shake = shk_acc_env_ff > Q_4_25;

   // Sequencer
   always_comb begin
      st_in            = st_ff;
      valid_seen_in    = valid_seen_ff;
      step_started_in  = step_started_ff;
      above_in         = above_ff;
      shake_started_in = shake_started_ff;
      shake_flag_in    = shake_flag_ff;
      step_pulse_in    = step_pulse_ff;
      act_pulse_in     = act_pulse_ff;
      baseline_in      = baseline_ff;
      step_env_in      = step_env_ff;
      prior_in         = prior_ff;
      ax_in            = ax_ff;
      now_in           = now_ff;
      last_step_in     = last_step_ff;
      last_shake_in    = last_shake_ff;
      last_act_in      = last_act_ff;
      sh_mag_in        = sh_mag_ff;
      sh_env_in        = sh_env_ff;
      sh_jerk_in       = sh_jerk_ff;
      shk_acc_env_in   = shk_acc_env_ff;
      shk_jerk_env_in  = shk_jerk_env_ff;
      act_env_in       = act_env_ff;
      mag_in           = mag_ff;
      jerk_in          = jerk_ff;
      hp_in            = hp_ff;
      sig_in           = sig_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      mac_cmd          = '0;
      sq_start         = 1'b0;
      req_ready        = (st_ff == S_IDLE);

      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               ax_in[0] = scale_axis(req_data.accel_x_raw, scale_sh);
               ax_in[1] = scale_axis(req_data.accel_y_raw, scale_sh);
               ax_in[2] = scale_axis(req_data.accel_z_raw, scale_sh);
               now_in   = req_data.time_ms;
               if (req_data.clear_shake) begin
                  shake_flag_in = 1'b0;
               end
               step_pulse_in = 1'b0;
               act_pulse_in  = 1'b0;
               st_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (valid_seen_ff || (abssum >= (AW+2)'(Q_1_100))) begin
               valid_seen_in = 1'b1;
               st_in = S_A1;
            end else begin
               st_in = S_DONE;
            end
         end
         // Activity detector on the previous envelope and jerk
         S_A1: begin
            mac_cmd = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_160, b: opnd(sh_env_ff)};
            st_in = S_A2;
         end
         S_A2: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: asad_pkg::C_055, b: opnd(sh_jerk_ff)};
            st_in = S_A3;
         end
         S_A3: begin
            sig_in  = mac_round;
            mac_cmd = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_060, b: opnd(act_env_ff)};
            st_in = S_A4;
         end
         S_A4: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: asad_pkg::C_040, b: opnd(sig_ff)};
            st_in = S_A5;
         end
         S_A5: begin
            act_env_in = mac_round;
            if ((mac_round > Q_7_100) && ((now_ff - last_act_ff) >= {16'd0, csr_holdoff_ff}))
            begin
               last_act_in  = now_ff;
               act_pulse_in = 1'b1;
            end
            st_in = S_P1;
         end
         // Sum of squares, then square root
         S_P1: begin
            mac_cmd = '{en: 1'b1, clr: 1'b1, a: 25'(ax_ff[0]), b: 25'(ax_ff[0])};
            st_in = S_P2;
         end
         S_P2: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: 25'(ax_ff[1]), b: 25'(ax_ff[1])};
            st_in = S_P3;
         end
         S_P3: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: 25'(ax_ff[2]), b: 25'(ax_ff[2])};
            st_in = S_P4;
         end
         S_P4: begin
            sq_start = 1'b1;
            st_in = S_PW;
         end
         S_PW: begin
            if (sq_done) begin
               mag_in = sq_root;
               st_in = S_T1;
            end
         end
         // Step detector
         S_T1: begin
            if (!step_started_ff) begin
               prior_in = ax_ff;
               baseline_in = (mag_ff > Q_1_20) ? mag_ff : Q_ONE;
               step_started_in = 1'b1;
               st_in = S_SH;
            end else if (mag_ff < Q_1_20) begin
               sh_mag_in  = mag_ff;
               sh_jerk_in = '0;
               above_in   = 1'b0;
               st_in = S_SH;
            end else begin
               jerk_in  = (|jerk_sum[AW+1:AW]) ? {AW{1'b1}} : jerk_sum[AW-1:0];
               prior_in = ax_ff;
               mac_cmd  = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_098, b: opnd(baseline_ff)};
               st_in = S_B2;
            end
         end
         S_B2: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: asad_pkg::C_002, b: opnd(mag_ff)};
            st_in = S_B3;
         end
         S_B3: begin
            baseline_in = mac_round;
            st_in = S_B4;
         end
         S_B4: begin
            hp_in   = absdiff_u(mag_ff, baseline_ff);
            mac_cmd = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_065, b: opnd(step_env_ff)};
            st_in = S_B5;
         end
         S_B5: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: asad_pkg::C_035, b: opnd(hp_ff)};
            st_in = S_B6;
         end
         S_B6: begin
            step_env_in = mac_round;
            sh_mag_in   = mag_ff;
            sh_env_in   = mac_round;
            sh_jerk_in  = jerk_ff;
            mac_cmd = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_035, b: opnd(env_thr_q)};
            st_in = S_B7;
         end
         S_B7: begin
            if (((over && !above_ff) || jerk_hit)
                && ((now_ff - last_step_ff) > {16'd0, csr_debounce_ff})) begin
               last_step_in  = now_ff;
               step_pulse_in = 1'b1;
            end
            above_in = over;
            st_in = S_SH;
         end
         // Shake detector, frozen while a shake is pending
         S_SH: begin
            if (shake_flag_ff) begin
               st_in = S_DONE;
            end else if (!shake_started_ff) begin
               shake_started_in = 1'b1;
               st_in = S_DONE;
            end else begin
               hp_in   = shake_hp;
               mac_cmd = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_035, b: opnd(shk_acc_env_ff)};
               st_in = S_K2;
            end
         end
         S_K2: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: asad_pkg::C_065, b: opnd(hp_ff)};
            st_in = S_K3;
         end
         S_K3: begin
            shk_acc_env_in = mac_round;
            mac_cmd = '{en: 1'b1, clr: 1'b1, a: asad_pkg::C_030, b: opnd(shk_jerk_env_ff)};
            st_in = S_K4;
         end
         S_K4: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: asad_pkg::C_070, b: opnd(sh_jerk_ff)};
            st_in = S_K5;
         end
         S_K5: begin
            shk_jerk_env_in = mac_round;
            if (((moved && jerked) || big_shake)
                && ((now_ff - last_shake_ff) >= {16'd0, csr_cooldown_ff})) begin
               last_shake_in = now_ff;
               shake_flag_in = 1'b1;
            end
            st_in = S_DONE;
         end
         // Hand the result over once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.step_pulse     = step_pulse_ff;
               rsp_data_in.shake_pending  = shake_flag_ff;
               rsp_data_in.activity_pulse = act_pulse_ff;
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff            <= S_IDLE;
         valid_seen_ff    <= 1'b0;
         step_started_ff  <= 1'b0;
         above_ff         <= 1'b0;
         shake_started_ff <= 1'b0;
         shake_flag_ff    <= 1'b0;
         step_pulse_ff    <= 1'b0;
         act_pulse_ff     <= 1'b0;
         baseline_ff      <= Q_ONE;
         step_env_ff      <= '0;
         prior_ff         <= '{default: '0};
         last_step_ff     <= '0;
         last_shake_ff    <= '0;
         last_act_ff      <= '0;
         sh_mag_ff        <= '0;
         sh_env_ff        <= '0;
         sh_jerk_ff       <= '0;
         shk_acc_env_ff   <= '0;
         shk_jerk_env_ff  <= '0;
         act_env_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         st_ff            <= st_in;
         valid_seen_ff    <= valid_seen_in;
         step_started_ff  <= step_started_in;
         above_ff         <= above_in;
         shake_started_ff <= shake_started_in;
         shake_flag_ff    <= shake_flag_in;
         step_pulse_ff    <= step_pulse_in;
         act_pulse_ff     <= act_pulse_in;
         baseline_ff      <= baseline_in;
         step_env_ff      <= step_env_in;
         prior_ff         <= prior_in;
         last_step_ff     <= last_step_in;
         last_shake_ff    <= last_shake_in;
         last_act_ff      <= last_act_in;
         sh_mag_ff        <= sh_mag_in;
         sh_env_ff        <= sh_env_in;
         sh_jerk_ff       <= sh_jerk_in;
         shk_acc_env_ff   <= shk_acc_env_in;
         shk_jerk_env_ff  <= shk_jerk_env_in;
         act_env_ff       <= act_env_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      now_ff      <= now_in;
      mag_ff      <= mag_in;
      jerk_ff     <= jerk_in;
      hp_ff       <= hp_in;
      sig_ff      <= sig_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_sqrt_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (st_ff == S_PW))
      else $error("square root finished outside its wait step");

   a_valid_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(valid_seen_ff))
      else $error("valid_seen cleared without reset");

   a_shake_set_in_k5: assert property (@(posedge clock) disable iff (reset)
      $rose(shake_flag_ff) |-> ($past(st_ff) == S_K5))
      else $error("shake flag set outside the shake decision step");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> (st_ff == S_DONE))
      else $error("result overwritten while receiver stalls");
`endif

endmodule

`default_nettype wire
